// ===== hw/rtl/mts_pkg.sv =====
// mts_pkg: shared types, action and register codes, melody rom and duty table
// for the melody tone sequencer. No dependencies.
`default_nettype none

package mts_pkg;

  localparam int DUTY_BITS    = 8;
  localparam int MELODY_COUNT = 10;
  localparam int MAX_NOTES    = 4;

  localparam int ROM_ROWS    = 16;
  localparam int ROM_COLS    = 8;
  localparam int VOL_ENTRIES = 128;
  localparam int PCT_FULL    = 100;
  localparam int DUTY_SAT    = 255;
  localparam int DUTY_MAX    = (1 << DUTY_BITS) - 1;

  // action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // configuration register indexes
  localparam int         CFG_IDX_W    = 1;
  localparam int         CFG_DATA_W   = 7;
  localparam logic [0:0] REG_SOUND_EN = 1'b0;
  localparam logic [0:0] REG_VOLUME   = 1'b1;

  localparam logic [6:0] VOLUME_RESET = 7'd50;

  typedef logic [9:0] hz_t;
  typedef logic [8:0] ms_t;
  typedef logic [3:0] len_t;
  typedef logic [7:0] duty_t;

  typedef hz_t   hz_row_t [ROM_COLS];
  typedef ms_t   ms_row_t [ROM_COLS];
  typedef duty_t duty_tab_t [VOL_ENTRIES];

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  melody_select;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [9:0] tone_hz;
    logic [7:0] pwm_duty;
    logic       is_playing;
  } out_item_t;

  // configuration state seen by the note engine
  typedef struct packed {
    logic  sound_enabled;
    duty_t duty;
    logic  clear;
  } cfg_ctl_t;

  localparam hz_row_t ROM_HZ [ROM_ROWS] = '{
    '{10'd523, 10'd659, 10'd784, 10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd880, 10'd0,   10'd880, 10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd500, 10'd400, 10'd300, 10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd200, 10'd0,   10'd150, 10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd600, 10'd700, 10'd600, 10'd700, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1000, 10'd0,  10'd0,   10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd600, 10'd500, 10'd400, 10'd300, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd523, 10'd659, 10'd784, 10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd150, 10'd0,   10'd0,   10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd900, 10'd0,   10'd0,   10'd0,   10'd0, 10'd0, 10'd0, 10'd0},
    '{default: 10'd0},
    '{default: 10'd0},
    '{default: 10'd0},
    '{default: 10'd0},
    '{default: 10'd0},
    '{default: 10'd0}
  };

  localparam ms_row_t ROM_MS [ROM_ROWS] = '{
    '{9'd130, 9'd130, 9'd130, 9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd60,  9'd40,  9'd60,  9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd120, 9'd120, 9'd120, 9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd150, 9'd30,  9'd100, 9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd70,  9'd70,  9'd70,  9'd70,  9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd80,  9'd0,   9'd0,   9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd120, 9'd160, 9'd200, 9'd260, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd130, 9'd130, 9'd130, 9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd90,  9'd0,   9'd0,   9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd25,  9'd0,   9'd0,   9'd0,   9'd0, 9'd0, 9'd0, 9'd0},
    '{default: 9'd0},
    '{default: 9'd0},
    '{default: 9'd0},
    '{default: 9'd0},
    '{default: 9'd0},
    '{default: 9'd0}
  };

  localparam len_t ROM_LEN [ROM_ROWS] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd1, 4'd4, 4'd3,
    4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // note count of a melody, capped at the longest melody the sequencer plays
  function automatic len_t melody_len(input logic [3:0] m);
    len_t n;
    n = ROM_LEN[m];
    if (n > len_t'(MAX_NOTES)) begin
      n = len_t'(MAX_NOTES);
    end
    return n;
  endfunction

  // duty for every volume code, evaluated at elaboration
  function automatic duty_tab_t build_duty_tab();
    duty_tab_t tab;
    int        vs;
    int        d;
    for (int v = 0; v < VOL_ENTRIES; v++) begin
      vs = (v > PCT_FULL) ? PCT_FULL : v;
      d  = DUTY_MAX * vs / PCT_FULL;
      if (d > DUTY_SAT) begin
        d = DUTY_SAT;
      end
      tab[v] = duty_t'(d);
    end
    return tab;
  endfunction

  localparam duty_tab_t DUTY_TAB = build_duty_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/mts_in_if.sv =====
// mts_in_if: input channel (action words) with valid/ready handshake.
// Field widths follow mts_pkg::in_item_t.
`default_nettype none

interface mts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  melody_select;
  logic [31:0] now_ms;

  modport source (output valid, output action, output melody_select, output now_ms,
                  input ready);
  modport sink (input valid, input action, input melody_select, input now_ms,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mts_out_if.sv =====
// mts_out_if: result channel (tone words) with valid/ready handshake.
// Field widths follow mts_pkg::out_item_t.
`default_nettype none

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] tone_hz;
  logic [7:0] pwm_duty;
  logic       is_playing;

  modport source (output valid, output tone_hz, output pwm_duty, output is_playing,
                  input ready);
  modport sink (input valid, input tone_hz, input pwm_duty, input is_playing,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mts_cfg_regs.sv =====
// mts_cfg_regs: sound enable and volume registers; volume is turned into a
// pwm duty at write time through mts_pkg::DUTY_TAB.
`default_nettype none

module mts_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mts_pkg::cfg_ctl_t                   ctl
);

  logic          en_r;
  logic          en_nxt;
  mts_pkg::duty_t duty_r;
  mts_pkg::duty_t duty_nxt;

  always_comb begin
    en_nxt   = en_r;
    duty_nxt = duty_r;
    if (cfg_we) begin
      case (cfg_index)
        mts_pkg::REG_SOUND_EN: en_nxt   = cfg_wdata[0];
        mts_pkg::REG_VOLUME:   duty_nxt = mts_pkg::DUTY_TAB[cfg_wdata];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      duty_r <= mts_pkg::DUTY_TAB[mts_pkg::VOLUME_RESET];
    end else begin
      en_r   <= en_nxt;
      duty_r <= duty_nxt;
    end
  end

  // disabling sound also stops whatever is playing
  assign ctl.sound_enabled = en_r;
  assign ctl.duty          = duty_r;
  assign ctl.clear         = cfg_we && (cfg_index == mts_pkg::REG_SOUND_EN) && !cfg_wdata[0];

endmodule

`default_nettype wire

// ===== hw/rtl/mts_note_engine.sv =====
// mts_note_engine: sequencer state (melody, note position, note start time)
// and the next-state and result logic for one word. Uses mts_pkg.
`default_nettype none

module mts_note_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire mts_pkg::in_item_t   item,
  input  wire mts_pkg::cfg_ctl_t   cfg,
  output mts_pkg::out_item_t       res
);

  logic        playing_r,  playing_nxt;
  logic [3:0]  melody_r,   melody_nxt;
  logic [2:0]  pos_r,      pos_nxt;
  logic [31:0] start_r,    start_nxt;
  logic        sounding_r, sounding_nxt;

  logic [31:0]       elapsed;
  mts_pkg::ms_t      cur_ms;
  logic [2:0]        pos_inc;
  mts_pkg::len_t     cur_len;
  mts_pkg::len_t     sel_len;
  logic              sel_valid;
  mts_pkg::hz_t      hz;

  assign elapsed   = item.now_ms - start_r;
  assign cur_ms    = mts_pkg::ROM_MS[melody_r][pos_r];
  assign pos_inc   = pos_r + 3'd1;
  assign cur_len   = mts_pkg::melody_len(melody_r);
  assign sel_len   = mts_pkg::melody_len(item.melody_select);
  assign sel_valid = {1'b0, item.melody_select} < 5'(mts_pkg::MELODY_COUNT);

  always_comb begin
    playing_nxt  = playing_r;
    melody_nxt   = melody_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    sounding_nxt = sounding_r;
    case (item.action)
      mts_pkg::ACT_TICK: begin
        if (playing_r && (elapsed >= {23'd0, cur_ms})) begin
          // position wraps at eight notes, which also ends the melody
          if ((pos_inc == 3'd0) || ({1'b0, pos_inc} >= cur_len)) begin
            playing_nxt  = 1'b0;
            melody_nxt   = 4'd0;
            pos_nxt      = 3'd0;
            sounding_nxt = 1'b0;
          end else begin
            pos_nxt      = pos_inc;
            sounding_nxt = 1'b1;
            start_nxt    = item.now_ms;
          end
        end
      end
      mts_pkg::ACT_PLAY: begin
        if (cfg.sound_enabled) begin
          sounding_nxt = 1'b0;
          if (sel_valid) begin
            melody_nxt = item.melody_select;
            pos_nxt    = 3'd0;
            if (sel_len == 4'd0) begin
              playing_nxt = 1'b0;
            end else begin
              playing_nxt  = 1'b1;
              sounding_nxt = 1'b1;
              start_nxt    = item.now_ms;
            end
          end
        end
      end
      mts_pkg::ACT_STOP: begin
        playing_nxt  = 1'b0;
        melody_nxt   = 4'd0;
        pos_nxt      = 3'd0;
        sounding_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r  <= 1'b0;
      melody_r   <= 4'd0;
      pos_r      <= 3'd0;
      start_r    <= 32'd0;
      sounding_r <= 1'b0;
    end else if (cfg.clear) begin
      playing_r  <= 1'b0;
      melody_r   <= 4'd0;
      pos_r      <= 3'd0;
      sounding_r <= 1'b0;
    end else if (step) begin
      playing_r  <= playing_nxt;
      melody_r   <= melody_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      sounding_r <= sounding_nxt;
    end
  end

  // result reflects the state after this word
  assign hz = (playing_nxt && sounding_nxt) ? mts_pkg::ROM_HZ[melody_nxt][pos_nxt] : 10'd0;

  assign res.tone_hz    = hz;
  assign res.pwm_duty   = (hz != 10'd0) ? cfg.duty : 8'd0;
  assign res.is_playing = playing_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/melody_tone_sequencer_core.sv =====
// melody_tone_sequencer_core: input register, note engine and result register.
// A word accepted into the input register passes through the note engine into the result
// register once that register is free. Throughput: one word per cycle while the result side is not stalled.
// Reset (rst_n low, synchronous): both stages empty, melody stopped,
// sound enabled, volume 50 percent.
`default_nettype none

module melody_tone_sequencer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mts_in_if.sink                              in_if,
  mts_out_if.source                           out_if,
  input  wire logic                           cfg_we,
  input  wire logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mts_pkg::cfg_ctl_t  cfg;
  mts_pkg::in_item_t  s1_r;
  logic               s1_v_r;
  mts_pkg::out_item_t res;
  mts_pkg::out_item_t out_r;
  logic               out_v_r;
  logic               out_free;
  logic               s1_fire;
  logic               in_fire;

  mts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (cfg)
  );

  assign out_free    = !out_v_r || out_if.ready;
  assign s1_fire     = s1_v_r && out_free;
  assign in_if.ready = !s1_v_r || s1_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.action        <= in_if.action;
      s1_r.melody_select <= in_if.melody_select;
      s1_r.now_ms        <= in_if.now_ms;
    end
  end

  mts_note_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_fire),
    .item  (s1_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.tone_hz    = out_r.tone_hz;
  assign out_if.pwm_duty   = out_r.pwm_duty;
  assign out_if.is_playing = out_r.is_playing;

  // an empty result register never holds back the input side
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_if.ready)
    else $error("input stalled with empty result register");

  // a stop word always yields a silent, stopped result
  a_stop_silences: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_r.action == mts_pkg::ACT_STOP))
      |=> (out_v_r && !out_r.is_playing && (out_r.tone_hz == 10'd0)))
    else $error("stop word left the melody running");

  // an enabled play of a valid melody starts it exactly when it has notes
  a_play_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_r.action == mts_pkg::ACT_PLAY) && cfg.sound_enabled && !cfg.clear
      && ({1'b0, s1_r.melody_select} < 5'(mts_pkg::MELODY_COUNT)))
      |=> (out_r.is_playing == (mts_pkg::melody_len($past(s1_r.melody_select)) != 4'd0)))
    else $error("play word did not start the selected melody");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for melody_tone_sequencer_core, with a tone
// predictor, random idle and stall mixes, and register writes between phases.
// Depends on mts_pkg, mts_in_if, mts_out_if and melody_tone_sequencer_core.

module tb;

  localparam logic [1:0] ACT_SPARE    = 2'd3;
  localparam int         TUNE_COUNT   = 10;
  localparam int         NOTE_CAP     = 4;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         PHASE_WORDS  = 350;
  localparam int         FULL_SCALE   = (1 << mts_pkg::DUTY_BITS) - 1;

  localparam logic [9:0] TUNE_HZ [16][8] = '{
    '{523, 659, 784, 0, 0, 0, 0, 0},
    '{880, 0, 880, 0, 0, 0, 0, 0},
    '{500, 400, 300, 0, 0, 0, 0, 0},
    '{200, 0, 150, 0, 0, 0, 0, 0},
    '{600, 700, 600, 700, 0, 0, 0, 0},
    '{1000, 0, 0, 0, 0, 0, 0, 0},
    '{600, 500, 400, 300, 0, 0, 0, 0},
    '{523, 659, 784, 0, 0, 0, 0, 0},
    '{150, 0, 0, 0, 0, 0, 0, 0},
    '{900, 0, 0, 0, 0, 0, 0, 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0}
  };

  localparam logic [8:0] TUNE_MS [16][8] = '{
    '{130, 130, 130, 0, 0, 0, 0, 0},
    '{60, 40, 60, 0, 0, 0, 0, 0},
    '{120, 120, 120, 0, 0, 0, 0, 0},
    '{150, 30, 100, 0, 0, 0, 0, 0},
    '{70, 70, 70, 70, 0, 0, 0, 0},
    '{80, 0, 0, 0, 0, 0, 0, 0},
    '{120, 160, 200, 260, 0, 0, 0, 0},
    '{130, 130, 130, 0, 0, 0, 0, 0},
    '{90, 0, 0, 0, 0, 0, 0, 0},
    '{25, 0, 0, 0, 0, 0, 0, 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0},
    '{default: 0}
  };

  localparam logic [3:0] TUNE_NOTES [16] = '{
    3, 3, 3, 3, 4, 1, 4, 3, 1, 1, 0, 0, 0, 0, 0, 0
  };

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mts_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mts_in_if  in_bus ();
  mts_out_if out_bus ();

  melody_tone_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic        snd_en;
  logic [6:0]  vol_pct;
  logic        tune_active;
  logic [3:0]  tune_sel;
  logic [2:0]  note_idx;
  logic [31:0] note_t0;
  logic        tone_on;

  mts_pkg::out_item_t tone_q [$];

  int src_idle_pct;
  int sink_stall_pct;
  int words_sent;
  int tones_checked;
  int reg_writes;
  int errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d tone words outstanding", $time, tone_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [3:0] tune_len(input logic [3:0] m);
    logic [3:0] n;
    n = TUNE_NOTES[m];
    if (n > 4'(NOTE_CAP)) n = 4'(NOTE_CAP);
    return n;
  endfunction

  function automatic logic [7:0] duty_for(input logic [6:0] v);
    int pct;
    int d;
    pct = (v > 100) ? 100 : int'(v);
    d = FULL_SCALE * pct / 100;
    if (d > 255) d = 255;
    return d[7:0];
  endfunction

  function automatic void silence_all();
    tune_active = 1'b0;
    tune_sel = 4'd0;
    note_idx = 3'd0;
    tone_on = 1'b0;
  endfunction

  function automatic void begin_note(input logic [31:0] now);
    if (note_idx >= tune_len(tune_sel)) begin
      tone_on = 1'b0;
      tune_active = 1'b0;
    end else begin
      tone_on = 1'b1;
      note_t0 = now;
    end
  endfunction

  // advances the predictor by one action word and returns the tone word
  function automatic mts_pkg::out_item_t next_tone(input logic [1:0] act,
                                                   input logic [3:0] sel,
                                                   input logic [31:0] now);
    mts_pkg::out_item_t r;
    logic [31:0] elapsed;
    elapsed = now - note_t0;
    case (act)
      mts_pkg::ACT_TICK: begin
        if (tune_active && elapsed >= 32'(TUNE_MS[tune_sel][note_idx])) begin
          note_idx = note_idx + 3'd1;
          if (note_idx == 3'd0 || note_idx >= tune_len(tune_sel)) silence_all();
          else begin_note(now);
        end
      end
      mts_pkg::ACT_PLAY: begin
        if (snd_en) begin
          tone_on = 1'b0;
          if (sel < TUNE_COUNT) begin
            tune_sel = sel;
            note_idx = 3'd0;
            tune_active = 1'b1;
            begin_note(now);
          end
        end
      end
      mts_pkg::ACT_STOP: silence_all();
      default: ;
    endcase
    r = '0;
    if (tune_active && tone_on) begin
      r.tone_hz = TUNE_HZ[tune_sel][note_idx];
      if (r.tone_hz != 10'd0) r.pwm_duty = duty_for(vol_pct);
    end
    r.is_playing = tune_active;
    return r;
  endfunction

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : tone_check
    mts_pkg::out_item_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (tone_q.size() == 0) begin
        $display("%0t: unexpected tone word, expected none, got hz=%0d duty=%0d playing=%0d",
                 $time, out_bus.tone_hz, out_bus.pwm_duty, out_bus.is_playing);
        errors++;
      end else begin
        want = tone_q.pop_front();
        tones_checked++;
        if (out_bus.tone_hz !== want.tone_hz) begin
          $display("%0t: tone_hz expected %0d got %0d", $time, want.tone_hz, out_bus.tone_hz);
          errors++;
        end
        if (out_bus.pwm_duty !== want.pwm_duty) begin
          $display("%0t: pwm_duty expected %0d got %0d", $time, want.pwm_duty,
                   out_bus.pwm_duty);
          errors++;
        end
        if (out_bus.is_playing !== want.is_playing) begin
          $display("%0t: is_playing expected %0d got %0d", $time, want.is_playing,
                   out_bus.is_playing);
          errors++;
        end
      end
    end
  end

  // presents one action word, holds it until accepted, then predicts its tone word
  task automatic send_word(input logic [1:0] act, input logic [3:0] sel,
                           input logic [31:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.melody_select <= sel;
    in_bus.now_ms <= now;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tone_q.push_back(next_tone(act, sel, now));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (tone_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mts_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mts_pkg::REG_SOUND_EN) begin
      snd_en = val[0];
      if (!snd_en) silence_all();
    end else begin
      vol_pct = val;
    end
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic test_note_sequence();
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd0);
    send_word(ACT_SPARE, 4'd15, 32'hFFFF_FFFF);
    send_word(mts_pkg::ACT_PLAY, 4'd0, 32'd100);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd229);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd230);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd360);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd489);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd490);
    // rest note in the middle
    send_word(mts_pkg::ACT_PLAY, 4'd1, 32'd1000);
    send_word(mts_pkg::ACT_TICK, 4'd1, 32'd1060);
    send_word(mts_pkg::ACT_TICK, 4'd1, 32'd1100);
    send_word(mts_pkg::ACT_TICK, 4'd1, 32'd1160);
  endtask

  task automatic test_wrap_and_invalid();
    send_word(mts_pkg::ACT_PLAY, 4'd9, 32'hFFFF_FFF0);
    send_word(mts_pkg::ACT_TICK, 4'd9, 32'h0000_0008);
    send_word(mts_pkg::ACT_TICK, 4'd9, 32'h0000_0009);
    // invalid select silences but keeps the note timer
    send_word(mts_pkg::ACT_PLAY, 4'd4, 32'd5000);
    send_word(mts_pkg::ACT_PLAY, 4'd15, 32'd5010);
    send_word(mts_pkg::ACT_TICK, 4'd4, 32'd5070);
    send_word(mts_pkg::ACT_PLAY, 4'd10, 32'd5080);
    send_word(mts_pkg::ACT_STOP, 4'd0, 32'd5090);
    send_word(mts_pkg::ACT_TICK, 4'd0, 32'd5200);
    send_word(mts_pkg::ACT_PLAY, 4'd10, 32'd0);
    // time running backwards looks like a huge elapsed time
    send_word(mts_pkg::ACT_PLAY, 4'd6, 32'd0);
    send_word(mts_pkg::ACT_TICK, 4'd6, 32'hFFFF_FFFF);
    send_word(mts_pkg::ACT_STOP, 4'd6, 32'd1);
  endtask

  task automatic test_register_effects();
    write_reg(mts_pkg::REG_VOLUME, 7'd0);
    send_word(mts_pkg::ACT_PLAY, 4'd5, 32'd10);
    write_reg(mts_pkg::REG_VOLUME, 7'd127);
    send_word(mts_pkg::ACT_PLAY, 4'd5, 32'd20);
    write_reg(mts_pkg::REG_VOLUME, 7'd100);
    send_word(mts_pkg::ACT_PLAY, 4'd8, 32'd30);
    // disabling stops the melody and blocks play
    write_reg(mts_pkg::REG_SOUND_EN, 7'h7E);
    send_word(mts_pkg::ACT_TICK, 4'd8, 32'd40);
    send_word(mts_pkg::ACT_PLAY, 4'd2, 32'd50);
    write_reg(mts_pkg::REG_SOUND_EN, 7'h01);
    send_word(mts_pkg::ACT_PLAY, 4'd2, 32'd60);
  endtask

  // one melody played with random timing, mixed with stops, restarts and noise
  task automatic random_tune();
    logic [31:0] t;
    logic [3:0]  sel;
    int          roll;
    t = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
    sel = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
    send_word(mts_pkg::ACT_PLAY, sel, t);
    repeat ($urandom_range(24, 4)) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_word(mts_pkg::ACT_STOP, 4'($urandom), t + $urandom_range(50));
      end else if (roll < 6) begin
        send_word(ACT_SPARE, 4'($urandom), $urandom);
      end else if (roll < 10) begin
        t = t + $urandom_range(100);
        send_word(mts_pkg::ACT_PLAY, 4'($urandom), t);
      end else if (roll < 12) begin
        send_word(mts_pkg::ACT_TICK, 4'($urandom), $urandom);
      end else begin
        t = t + (($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(40));
        send_word(mts_pkg::ACT_TICK, 4'($urandom), t);
      end
    end
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct,
                                     input logic [6:0] vol, input int count);
    int target;
    write_reg(mts_pkg::REG_VOLUME, vol);
    src_idle_pct = in_pct;
    sink_stall_pct = out_pct;
    target = words_sent + count;
    while (words_sent < target) random_tune();
  endtask

  task automatic test_disabled_traffic();
    write_reg(mts_pkg::REG_SOUND_EN, 7'h00);
    repeat (4) random_tune();
    write_reg(mts_pkg::REG_SOUND_EN, 7'h01);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = mts_pkg::ACT_TICK;
    in_bus.melody_select = 4'd0;
    in_bus.now_ms = 32'd0;
    out_bus.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    words_sent = 0;
    tones_checked = 0;
    reg_writes = 0;
    errors = 0;
    snd_en = 1'b1;
    vol_pct = mts_pkg::VOLUME_RESET;
    note_t0 = 32'd0;
    silence_all();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_note_sequence();
    test_wrap_and_invalid();
    test_register_effects();
    test_random_traffic(0, 0, 7'd50, PHASE_WORDS);
    test_random_traffic(79, 0, 7'($urandom_range(99, 1)), PHASE_WORDS);
    test_disabled_traffic();
    test_random_traffic(0, 79, 7'd127, PHASE_WORDS);
    test_random_traffic(23, 23, 7'($urandom_range(127)), PHASE_WORDS);

    wait_idle();
    $display("run: %0d action words, %0d tone words checked, %0d register writes",
             words_sent, tones_checked, reg_writes);
    $display("run: all melodies, invalid and disabled plays, stops, timer wrap, four idle mixes");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== melody_tone_sequencer_core.f =====
hw/rtl/mts_pkg.sv
hw/rtl/mts_in_if.sv
hw/rtl/mts_out_if.sv
hw/rtl/mts_cfg_regs.sv
hw/rtl/mts_note_engine.sv
hw/rtl/melody_tone_sequencer_core.sv
verif/tb.sv
